@@ design/sida_pkg.sv @@
// sida_pkg: shared types and constants for the signed integer to decimal ascii unit
// no dependencies; imported by the controller, datapath, top level and checker

package sida_pkg;

	// magnitude and bcd geometry
	localparam int MAG_W       = 16;
	localparam int NUM_DIGITS  = 5;
	localparam int BCD_W       = 4 * NUM_DIGITS;
	localparam int DCNT_W      = 3;
	localparam int SHIFT_STEPS = MAG_W;
	localparam int STEP_W      = $clog2(SHIFT_STEPS);

	// character codes
	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] MINUS_CODE = 8'd45;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture sign and magnitude of a new request
		logic shift;  // one double-dabble step
		logic norm;   // count digits and left-align the bcd word
		logic emit;   // move the next character into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic next_last;  // the character about to be emitted ends the text
	} stat_t;

endpackage

@@ design/sida_dp.sv @@
// sida_dp: datapath with magnitude register, bit-serial binary to bcd converter
// and output character register; depends on sida_pkg

module sida_dp (
	input  logic                clk,
	input  logic signed [15:0]  value,
	input  sida_pkg::cmd_t      cmd,
	output sida_pkg::stat_t     stat,
	output logic [7:0]          char_code,
	output logic                last
);
	import sida_pkg::*;

	logic [MAG_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [DCNT_W-1:0] ndig_q;
	logic              sign_pend_q;
	logic [7:0]        char_q;
	logic              last_q;

	logic [MAG_W-1:0]  abs_c;
	logic [BCD_W-1:0]  adj_c;
	logic [DCNT_W-1:0] ndig_c;
	logic [BCD_W-1:0]  align_c;
	logic [7:0]        next_char_c;
	logic              next_last_c;

	// magnitude; negating -32768 in 16 bits gives 0x8000, read unsigned as 32768
	assign abs_c = value[MAG_W-1] ? MAG_W'(-value) : MAG_W'(value);

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj_c[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// digit count: position of the highest nonzero digit, at least one
	always_comb begin
		ndig_c = DCNT_W'(1);
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig_c = DCNT_W'(i + 1);
			end
		end
	end

	// left-align so the leading digit sits in the top nibble
	always_comb begin
		unique case (ndig_c)
			3'd5:    align_c = bcd_q;
			3'd4:    align_c = {bcd_q[BCD_W-5:0], 4'd0};
			3'd3:    align_c = {bcd_q[BCD_W-9:0], 8'd0};
			3'd2:    align_c = {bcd_q[BCD_W-13:0], 12'd0};
			default: align_c = {bcd_q[BCD_W-17:0], 16'd0};
		endcase
	end

	// next character: pending minus sign first, then the top digit
	assign next_char_c = sign_pend_q ? MINUS_CODE
		: DIGIT_BASE + {4'd0, bcd_q[BCD_W-1 -: 4]};
	assign next_last_c = !sign_pend_q && (ndig_q == DCNT_W'(1));

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q       <= abs_c;
			bcd_q       <= '0;
			sign_pend_q <= value[MAG_W-1];
		end else if (cmd.shift) begin
			bcd_q <= {adj_c[BCD_W-2:0], mag_q[MAG_W-1]};
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end else if (cmd.norm) begin
			bcd_q  <= align_c;
			ndig_q <= ndig_c;
		end else if (cmd.emit) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
				ndig_q <= ndig_q - DCNT_W'(1);
			end
		end
	end

	// output character register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= next_char_c;
			last_q <= next_last_c;
		end
	end

	assign stat.next_last = next_last_c;
	assign char_code      = char_q;
	assign last           = last_q;

endmodule

@@ design/sida_ctrl.sv @@
// sida_ctrl: controller state machine sequencing load, conversion, alignment and emit
// depends on sida_pkg

module sida_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  sida_pkg::stat_t stat,
	output sida_pkg::cmd_t  cmd
);
	import sida_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_NORM = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;

	// output register may take a new character when empty or being drained
	assign slot_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (step_q == STEP_W'(SHIFT_STEPS - 1)) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (stat.next_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.shift) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// Converts one signed 16-bit value per request into its decimal ASCII text, one
// character per output request: a '-' first for negative values, then the digits most
// significant first with no leading zeros ("0" for zero, "-32768" for the most
// negative value), with last set on the final character. A request passes through a
// load step, the 16-step bit-serial binary to bcd loop, an alignment step and one emit
// step per character (1 to 6), which waits while the output is stalled. A new request
// is taken only once the previous text has been moved into the output register, which
// holds the final character while the next value is accepted.
// depends on sida_pkg, sida_ctrl, sida_dp

module signed_int_to_decimal_ascii_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char_code,
	output logic               last
);
	import sida_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	sida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// conversion and output registers
	sida_dp u_dp (
		.clk       (clk),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.char_code (char_code),
		.last      (last)
	);

endmodule

@@ design/sida_checker.sv @@
// sida_checker: port-level assertions for the decimal ascii unit, bound to the top level
// depends on the top level port list and the character codes in sida_pkg

module sida_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic signed [15:0] value,
	input logic              out_valid,
	input logic              out_stall,
	input logic [7:0]        char_code,
	input logic              last
);
	import sida_pkg::*;

	// a stalled output request holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
		else $error("stalled output request changed");

	// one request at a time: conversion blocks the input right after acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted during conversion");

	// every character is a minus sign or a decimal digit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == MINUS_CODE)
			|| ((char_code >= DIGIT_BASE) && (char_code <= DIGIT_BASE + 8'd9)))
		else $error("character outside minus and digits");

	// the minus sign never ends a text
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == MINUS_CODE) |-> !last)
		else $error("minus sign marked last");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (.*);
